### sv/tqs_pkg.sv
// Package for the tone queue synth voice: item and queue entry types,
// controller command and status structs, constants and the sine table function.
// Used by every module of the block but tqs_ram; depends on nothing.
`default_nettype none

package tqs_pkg;

    localparam logic [2:0] WAVE_SILENT   = 3'd0;
    localparam logic [2:0] WAVE_SINE     = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_SAW      = 3'd4;
    localparam logic [2:0] WAVE_ORGAN    = 3'd5;

    localparam logic [15:0] SUSTAIN_RESET = 16'd52429;
    localparam logic [14:0] AMP_FULL      = 15'd28000;
    localparam logic [8:0]  LEN_MUL       = 9'd441;
    localparam logic [24:0] LEN_RECIP     = 25'd26843546;
    localparam int          LEN_SHIFT     = 28;
    localparam int          DIV_STEPS     = 39;
    localparam logic [2:0]  ORGAN_HARMS   = 3'd6;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic        req_type;
        logic [23:0] phase_step;
        logic [15:0] duration_ms;
        logic [2:0]  waveform;
        logic [8:0]  velocity;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               accepted;
        logic               playing;
        logic [6:0]         queue_count;
    } out_item_t;

    typedef struct packed {
        logic [23:0] step;
        logic [21:0] length;
        logic [2:0]  wave;
        logic [8:0]  vel;
    } tone_entry_t;

    typedef struct packed {
        logic capture;
        logic len_calc;
        logic head_read;
        logic setup;
        logic rom_idx;
        logic rom_read;
        logic rom_acc;
        logic div_step;
        logic mul1;
        logic mul2;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic silent;
        logic uses_rom;
        logic rom_last;
        logic div_last;
    } ctrl_status_t;

    // Sine table entry for a Q32 phase, quarter-wave Taylor series in Q30.
    function automatic logic signed [15:0] sine_value(input logic [63:0] u);
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        quad = (u >> 30) & 64'd3;
        r = u & (Q30_ONE - 64'd1);
        if (quad[0])
        begin
            r = Q30_ONE - r;
        end
        x = (r * Q30_HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 64'd72;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return quad[1] ? -signed'(16'(v)) : signed'(16'(v));
    endfunction

endpackage

`default_nettype wire

### sv/tqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the tone queue; depends on nothing.
`default_nettype none

module tqs_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/tqs_datapath.sv
// Datapath of the tone queue synth voice: queue pointers, tone length scaling,
// waveform, envelope divider, amplitude products and the result register.
// Depends on tqs_pkg and tqs_ram.
`default_nettype none

module tqs_datapath #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tqs_pkg::in_item_t     in_data,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_data,
    input  wire tqs_pkg::ctrl_cmd_t    cmd,
    output tqs_pkg::ctrl_status_t      status,
    output tqs_pkg::out_item_t         out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EW = $bits(tqs_pkg::tone_entry_t);

    localparam logic [1:0] ENV_DECAY   = 2'd0;
    localparam logic [1:0] ENV_RELEASE = 2'd1;
    localparam logic [1:0] ENV_SUSTAIN = 2'd2;

    logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] U = (64'(g) << 32) / SINE_TABLE_DEPTH;
        localparam logic signed [15:0] V = tqs_pkg::sine_value(U);
        assign sine_rom[g] = V;
    end

    logic [15:0]            sustain_reg;
    logic [AW-1:0]          head_reg;
    logic [CW-1:0]          count_reg;
    logic [23:0]            phase_reg;
    logic [21:0]            done_reg;
    logic                   req_reg;
    tqs_pkg::in_item_t      item_reg;
    logic [24:0]            x_reg;
    logic [21:0]            len_reg;
    tqs_pkg::tone_entry_t   entry_reg;
    logic                   silent_reg;
    logic [1:0]             env_mode_reg;
    logic [23:0]            amp_reg;
    logic [2:0]             harm_cnt_reg;
    logic [2:0]             harm_total_reg;
    logic [23:0]            phk_reg;
    logic [IW-1:0]          idx_reg;
    logic signed [15:0]     rom_q_reg;
    logic signed [18:0]     sum_reg;
    logic [38:0]            quo_reg;
    logic [21:0]            rem_reg;
    logic [21:0]            div_reg;
    logic [5:0]             div_cnt_reg;
    logic [16:0]            env_reg;
    logic signed [42:0]     p1_reg;
    logic signed [60:0]     p2_reg;
    tqs_pkg::out_item_t     out_reg;

    logic [EW-1:0]          rd_bits;
    tqs_pkg::tone_entry_t   rd_entry;
    tqs_pkg::tone_entry_t   wr_entry;
    logic                   enq_ok;
    logic                   ram_we;
    logic [AW:0]            tail_sum;
    logic [AW-1:0]          tail;
    logic [AW-1:0]          head_inc;

    assign rd_entry = tqs_pkg::tone_entry_t'(rd_bits);
    assign wr_entry = '{step: item_reg.phase_step, length: len_reg,
                        wave: item_reg.waveform, vel: item_reg.velocity};
    assign enq_ok = (count_reg < CW'(QUEUE_DEPTH)) && (len_reg != '0);
    assign ram_we = cmd.commit && !req_reg && enq_ok;
    assign tail_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail = (tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                ? AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    tqs_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (tail),
        .wr_data (EW'(wr_entry)),
        .rd_en   (cmd.head_read),
        .rd_addr (head_reg),
        .rd_data (rd_bits)
    );

    // Envelope segment selection and divider operands from the head tone.
    logic [24:0] t7;
    logic [21:0] dec;
    logic [21:0] rel;
    logic        in_decay;
    logic        in_release;
    logic [16:0] s17;
    logic [16:0] mul_a;
    logic [21:0] mul_b;
    logic [38:0] num;

    assign t7 = 25'(rd_entry.length) * 25'd7;
    assign dec = t7[24:3];
    assign rel = {3'b000, rd_entry.length[21:3]};
    assign in_decay = done_reg < dec;
    assign in_release = (rel != '0) && (done_reg > rd_entry.length - rel)
                      && (done_reg <= rd_entry.length);
    assign s17 = {1'b0, sustain_reg};
    assign mul_a = in_decay ? (17'd65536 - s17) : s17;
    assign mul_b = in_decay ? done_reg : rd_entry.length - done_reg;
    assign num = 39'(mul_a) * 39'(mul_b);

    logic [23+DW:0] idx_prod;
    logic signed [18:0] h19;
    logic signed [18:0] h_add;
    logic [22:0] trial;
    logic        ge;

    assign idx_prod = (24 + DW)'(phk_reg) * (24 + DW)'(SINE_TABLE_DEPTH);
    assign h19 = 19'(rom_q_reg);
    assign h_add = (harm_cnt_reg == 3'd3) ? h19 + (h19 <<< 1) : h19;
    assign trial = {rem_reg, quo_reg[38]};
    assign ge = trial >= {1'b0, div_reg};

    logic signed [17:0] w;
    logic signed [17:0] q18;
    logic signed [18:0] organ_sum;
    logic [16:0]        env_val;

    assign q18 = signed'({1'b0, phase_reg[23:7]});
    assign organ_sum = sum_reg + ((sum_reg < 0) ? 19'sd7 : 19'sd0);

    always_comb
    begin
        unique case (entry_reg.wave)
            tqs_pkg::WAVE_SINE:     w = 18'(sum_reg);
            tqs_pkg::WAVE_SQUARE:   w = (sum_reg > 0) ? 18'sd32768 : -18'sd32768;
            tqs_pkg::WAVE_TRIANGLE:
            begin
                if (phase_reg < 24'h400000)
                begin
                    w = q18;
                end
                else if (phase_reg < 24'hC00000)
                begin
                    w = 18'sd65536 - q18;
                end
                else
                begin
                    w = q18 - 18'sd131072;
                end
            end
            tqs_pkg::WAVE_SAW:      w = signed'({2'b00, phase_reg[23:8]}) - 18'sd32768;
            tqs_pkg::WAVE_ORGAN:    w = 18'(organ_sum >>> 3);
            default:                w = '0;
        endcase
    end

    always_comb
    begin
        unique case (env_mode_reg)
            ENV_DECAY:   env_val = 17'd65536 - quo_reg[16:0];
            ENV_RELEASE: env_val = quo_reg[16:0];
            default:     env_val = s17;
        endcase
    end

    // Scale down by 2^39 toward zero, then clamp to 16 bits.
    logic signed [60:0] p2_adj;
    logic signed [21:0] scaled;
    logic signed [15:0] sat;

    assign p2_adj = p2_reg + (p2_reg[60] ? 61'sh7F_FFFF_FFFF : 61'sd0);
    assign scaled = p2_adj[60:39];
    assign sat = (scaled > 22'sd32767) ? 16'sh7FFF
               : (scaled < -22'sd32768) ? 16'sh8000 : 16'(scaled);

    logic [21:0]   done_inc;
    logic          tone_end;
    logic          tick_live;
    logic [CW-1:0] count_after;

    assign done_inc = done_reg + 22'd1;
    assign tone_end = done_inc >= entry_reg.length;
    assign tick_live = count_reg != '0;

    always_comb
    begin
        if (!req_reg)
        begin
            count_after = enq_ok ? count_reg + 1'b1 : count_reg;
        end
        else if (tick_live && tone_end)
        begin
            count_after = count_reg - 1'b1;
        end
        else
        begin
            count_after = count_reg;
        end
    end

    logic [49:0] len_prod;
    assign len_prod = 50'(x_reg) * 50'(tqs_pkg::LEN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sustain_reg <= tqs_pkg::SUSTAIN_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            phase_reg   <= '0;
            done_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                sustain_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                count_reg <= count_after;
                if (req_reg && tick_live)
                begin
                    if (tone_end)
                    begin
                        head_reg  <= head_inc;
                        done_reg  <= '0;
                        phase_reg <= '0;
                    end
                    else
                    begin
                        done_reg  <= done_inc;
                        phase_reg <= phase_reg + entry_reg.step;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= in_data.req_type;
            item_reg <= in_data;
            x_reg    <= 25'(in_data.duration_ms) * 25'(tqs_pkg::LEN_MUL);
        end
        if (cmd.len_calc)
        begin
            len_reg <= len_prod[tqs_pkg::LEN_SHIFT +: 22];
        end
        if (cmd.setup)
        begin
            entry_reg      <= rd_entry;
            silent_reg     <= status.silent;
            env_mode_reg   <= in_decay ? ENV_DECAY : (in_release ? ENV_RELEASE : ENV_SUSTAIN);
            quo_reg        <= num;
            rem_reg        <= '0;
            div_reg        <= in_decay ? dec : rel;
            div_cnt_reg    <= '0;
            amp_reg        <= 24'(tqs_pkg::AMP_FULL) * 24'(rd_entry.vel);
            harm_cnt_reg   <= 3'd1;
            harm_total_reg <= (rd_entry.wave == tqs_pkg::WAVE_ORGAN)
                              ? tqs_pkg::ORGAN_HARMS : 3'd1;
            phk_reg        <= phase_reg;
            sum_reg        <= '0;
        end
        if (cmd.rom_idx)
        begin
            idx_reg <= idx_prod[24 +: IW];
        end
        if (cmd.rom_read)
        begin
            rom_q_reg <= sine_rom[idx_reg];
        end
        if (cmd.rom_acc)
        begin
            sum_reg      <= sum_reg + h_add;
            phk_reg      <= phk_reg + phase_reg;
            harm_cnt_reg <= harm_cnt_reg + 3'd1;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= ge ? 22'(trial - {1'b0, div_reg}) : trial[21:0];
            quo_reg     <= {quo_reg[37:0], ge};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        if (cmd.mul1)
        begin
            p1_reg  <= 43'(signed'({1'b0, amp_reg})) * 43'(w);
            env_reg <= env_val;
        end
        if (cmd.mul2)
        begin
            p2_reg <= 61'(p1_reg) * 61'(signed'({1'b0, env_reg}));
        end
        if (cmd.commit)
        begin
            out_reg.sample      <= (!req_reg || silent_reg) ? 16'sd0 : sat;
            out_reg.accepted    <= !req_reg && enq_ok;
            out_reg.playing     <= count_after != '0;
            out_reg.queue_count <= 7'(count_after);
        end
    end

    assign status.in_tick  = in_data.req_type;
    assign status.silent   = (count_reg == '0) || (rd_entry.step == '0);
    assign status.uses_rom = (rd_entry.wave == tqs_pkg::WAVE_SINE)
                          || (rd_entry.wave == tqs_pkg::WAVE_SQUARE)
                          || (rd_entry.wave == tqs_pkg::WAVE_ORGAN);
    assign status.rom_last = harm_cnt_reg == harm_total_reg;
    assign status.div_last = div_cnt_reg == 6'(tqs_pkg::DIV_STEPS - 1);
    assign out_data = out_reg;

endmodule

`default_nettype wire

### sv/tqs_ctrl.sv
// Controller of the tone queue synth voice: sequences enqueue and sample items
// through the datapath and owns the input and output handshakes.
// Depends on tqs_pkg.
`default_nettype none

module tqs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire tqs_pkg::ctrl_status_t status,
    output tqs_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_LEN,
        S_HEAD_RD,
        S_SETUP,
        S_ROM_IDX,
        S_ROM_RD,
        S_ROM_ACC,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = status.in_tick ? S_HEAD_RD : S_ENQ_LEN;
                end
            end
            S_ENQ_LEN:
            begin
                cmd.len_calc = 1'b1;
                state_next = S_COMMIT;
            end
            S_HEAD_RD:
            begin
                cmd.head_read = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                priority if (status.silent)
                begin
                    state_next = S_COMMIT;
                end
                else if (status.uses_rom)
                begin
                    state_next = S_ROM_IDX;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_ROM_IDX:
            begin
                cmd.rom_idx = 1'b1;
                state_next = S_ROM_RD;
            end
            S_ROM_RD:
            begin
                cmd.rom_read = 1'b1;
                state_next = S_ROM_ACC;
            end
            S_ROM_ACC:
            begin
                cmd.rom_acc = 1'b1;
                state_next = status.rom_last ? S_DIV : S_ROM_IDX;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### sv/tone_queue_synth_voice.sv
// An enqueue item is captured, has its length scaled and is committed. A sample tick
// reads the queue head and commits at once on an empty queue or a silent tone; else
// it does the table reads (one for sine and square, six for organ, none for triangle
// and saw), the bit-serial envelope divider and two products. One item is in work at
// a time; the next is accepted the cycle after a result is registered.
// Reset clears the queue pointers, phase and sample count, and sets sustain to 0.8.
`default_nettype none

module tone_queue_synth_voice #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tqs_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tqs_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);

    tqs_pkg::ctrl_cmd_t    cmd;
    tqs_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    tqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tqs_datapath #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### sv/tqs_checker.sv
// Port-level checks for the tone queue synth voice and the bind that attaches them.
// Depends on tqs_pkg and tone_queue_synth_voice.
`default_nettype none

module tqs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire tqs_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result changed or dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("A second item was taken while one is in work.");

    a_enq_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accepted |-> out_data.sample == 16'sd0)
        else $error("An accepted enqueue item carries a sample.");

    a_playing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.playing == (out_data.queue_count != 7'd0))
        else $error("Playing flag disagrees with the queue count.");

endmodule

bind tone_queue_synth_voice tqs_checker u_tqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

### sim/tone_voice_checker.sv
// Checker for the tone queue synth voice: watches the item, result and sustain
// channels, predicts every result from its own model of the voice and compares.
// Depends on tqs_pkg for the item types and waveform codes.
`timescale 1ns / 1ps

module tone_voice_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire tqs_pkg::in_item_t   in_data,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire tqs_pkg::out_item_t  out_data,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [15:0]         cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    localparam logic REQ_TICK = 1'b1;
    localparam int TONE_SLOTS = 64;
    localparam logic [63:0] Q30_UNIT = 64'd1073741824;
    localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;

    logic [23:0] tone_step [TONE_SLOTS];
    logic [21:0] tone_len [TONE_SLOTS];
    logic [2:0]  tone_wave [TONE_SLOTS];
    logic [8:0]  tone_vel [TONE_SLOTS];
    logic [5:0]  head_slot;
    logic [6:0]  tones_held;
    logic [23:0] phase;
    logic [21:0] played;
    logic [15:0] sustain;
    tqs_pkg::out_item_t expected_q[$];

    function automatic longint sine_lookup(input logic [23:0] ph);
        logic [63:0] u;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        u = 64'(ph[23:16]) << 24;
        quad = (u >> 30) & 64'd3;
        r = u & (Q30_UNIT - 64'd1);
        if (quad[0])
        begin
            r = Q30_UNIT - r;
        end
        x = (r * Q30_QUARTER_TURN) >> 30;
        x2 = (x * x) >> 30;
        t = Q30_UNIT - x2 / 64'd72;
        t = Q30_UNIT - ((x2 * t) >> 30) / 64'd42;
        t = Q30_UNIT - ((x2 * t) >> 30) / 64'd20;
        t = Q30_UNIT - ((x2 * t) >> 30) / 64'd6;
        v = (((x * t) >> 30) * 64'd32767 + (Q30_UNIT >> 1)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint wave_level(input logic [2:0] wave, input logic [23:0] ph);
        longint q;
        longint sum;
        logic [23:0] harm_ph;
        q = longint'(ph >> 7);
        sum = 0;
        case (wave)
            tqs_pkg::WAVE_SINE: return sine_lookup(ph);
            tqs_pkg::WAVE_SQUARE: return (sine_lookup(ph) > 0) ? 32768 : -32768;
            tqs_pkg::WAVE_TRIANGLE:
            begin
                if (ph < 24'h400000)
                begin
                    return q;
                end
                if (ph < 24'hC00000)
                begin
                    return 65536 - q;
                end
                return q - 131072;
            end
            tqs_pkg::WAVE_SAW: return longint'(ph >> 8) - 32768;
            tqs_pkg::WAVE_ORGAN:
            begin
                for (int k = 1; k <= 6; k++)
                begin
                    harm_ph = 24'(64'(ph) * 64'(k));
                    sum += (k == 3) ? 3 * sine_lookup(harm_ph) : sine_lookup(harm_ph);
                end
                return sum / 8;
            end
            default: return 0;
        endcase
    endfunction

    function automatic longint envelope_level(input longint total, input longint p);
        longint decay_len;
        longint release_len;
        decay_len = 7 * total / 8;
        release_len = total / 8;
        if (p < decay_len)
        begin
            return 65536 - ((65536 - longint'(sustain)) * p) / decay_len;
        end
        if (release_len != 0 && p > total - release_len && p <= total)
        begin
            return longint'(sustain) * (total - p) / release_len;
        end
        return longint'(sustain);
    endfunction

    function automatic tqs_pkg::out_item_t voice_step(input tqs_pkg::in_item_t it);
        tqs_pkg::out_item_t res;
        logic [31:0] len;
        logic [5:0]  slot;
        longint      level;
        res = '0;
        if (it.req_type != REQ_TICK)
        begin
            len = (32'(it.duration_ms) * 32'd44100) / 32'd1000;
            if (tones_held < 7'(TONE_SLOTS) && len != 0)
            begin
                slot = head_slot + 6'(tones_held);
                tone_step[slot] = it.phase_step;
                tone_len[slot] = 22'(len);
                tone_wave[slot] = it.waveform;
                tone_vel[slot] = it.velocity;
                tones_held++;
                res.accepted = 1'b1;
            end
        end
        else if (tones_held != 0)
        begin
            if (tone_step[head_slot] != 0)
            begin
                level = 28000 * longint'(tone_vel[head_slot])
                    * wave_level(tone_wave[head_slot], phase)
                    * envelope_level(longint'(tone_len[head_slot]), longint'(played));
                level = level / (longint'(1) << 39);
                if (level > 32767)
                begin
                    level = 32767;
                end
                if (level < -32768)
                begin
                    level = -32768;
                end
                res.sample = 16'(level);
            end
            played++;
            phase = phase + tone_step[head_slot];
            if (played >= tone_len[head_slot])
            begin
                head_slot++;
                tones_held--;
                played = '0;
                phase = '0;
            end
        end
        res.playing = (tones_held != 0);
        res.queue_count = tones_held;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tqs_pkg::out_item_t want;
        if (!rst_n)
        begin
            head_slot = '0;
            tones_held = '0;
            phase = '0;
            played = '0;
            sustain = tqs_pkg::SUSTAIN_RESET;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sustain = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(voice_step(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("Result arrived with no item waiting for one.");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (out_data.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
                        fail_count++;
                    end
                    if (out_data.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d",
                            want.accepted, out_data.accepted);
                        fail_count++;
                    end
                    if (out_data.playing !== want.playing)
                    begin
                        $error("playing: expected %0d, got %0d", want.playing, out_data.playing);
                        fail_count++;
                    end
                    if (out_data.queue_count !== want.queue_count)
                    begin
                        $error("queue_count: expected %0d, got %0d",
                            want.queue_count, out_data.queue_count);
                        fail_count++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

### sim/tone_queue_synth_voice_test.sv
// Top of the tone queue synth voice testbench: clock, reset, stimulus and verdict.
// Depends on tqs_pkg, the tone_queue_synth_voice block and tone_voice_checker.
`timescale 1ns / 1ps

module tone_queue_synth_voice_test;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam int DRAIN_CYCLES = 80;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    tqs_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tqs_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 items_sent = 0;
    int                 ticks_sent = 0;

    always #5 clk = ~clk;

    tone_queue_synth_voice u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tone_voice_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic tqs_pkg::in_item_t tone_item(input logic [23:0] step,
                                                    input logic [15:0] dur,
                                                    input logic [2:0] wave,
                                                    input logic [8:0] vel);
        tqs_pkg::in_item_t it;
        it.req_type = REQ_ENQUEUE;
        it.phase_step = step;
        it.duration_ms = dur;
        it.waveform = wave;
        it.velocity = vel;
        return it;
    endfunction

    function automatic tqs_pkg::in_item_t tick_item();
        tqs_pkg::in_item_t it;
        it = tqs_pkg::in_item_t'($bits(tqs_pkg::in_item_t)'({$urandom, $urandom}));
        it.req_type = REQ_TICK;
        return it;
    endfunction

    function automatic tqs_pkg::in_item_t random_tone(input logic [15:0] dur);
        logic [23:0] step;
        logic [8:0]  vel;
        step = 24'($urandom);
        if ($urandom_range(9) == 0)
        begin
            step = '0;
        end
        else if ($urandom_range(9) == 0)
        begin
            step = '1;
        end
        vel = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(256));
        return tone_item(step, dur, 3'($urandom_range(7)), vel);
    endfunction

    task automatic send_item(input tqs_pkg::in_item_t it);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (it.req_type == REQ_TICK)
        begin
            ticks_sent++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sustain(input logic [15:0] level);
        cfg_valid <= 1'b1;
        cfg_data <= level;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input bit fill_first);
        logic [15:0] dur;
        if (fill_first)
        begin
            repeat (66) send_item(random_tone(16'd1));
        end
        repeat (count)
        begin
            if ($urandom_range(99) < 8)
            begin
                dur = 16'($urandom_range(1, 3));
                if ($urandom_range(19) == 0)
                begin
                    dur = '0;
                end
                else if ($urandom_range(9) == 0)
                begin
                    dur = 16'($urandom_range(4, 8));
                end
                send_item(random_tone(dur));
            end
            else
            begin
                send_item(tick_item());
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tone_item(24'h123456, 16'd0, tqs_pkg::WAVE_SINE, 9'd256));
        send_item(tick_item());
        send_item(tone_item(24'hFFFFFF, 16'd1, tqs_pkg::WAVE_SINE, 9'd256));
        send_item(tone_item(24'h010000, 16'd1, tqs_pkg::WAVE_SQUARE, 9'd511));
        send_item(tone_item(24'h020000, 16'd1, tqs_pkg::WAVE_TRIANGLE, 9'd256));
        send_item(tone_item(24'h030000, 16'd1, tqs_pkg::WAVE_SAW, 9'd300));
        send_item(tone_item(24'h00F000, 16'd1, tqs_pkg::WAVE_ORGAN, 9'd256));
        send_item(tone_item(24'h000000, 16'd1, tqs_pkg::WAVE_ORGAN, 9'd256));
        send_item(tone_item(24'h040000, 16'd1, tqs_pkg::WAVE_SILENT, 9'd256));
        send_item(tone_item(24'h040000, 16'd1, 3'd6, 9'd256));
        send_item(tone_item(24'h040000, 16'd1, 3'd7, 9'd0));
        repeat (12) send_item(tick_item());

        tx_idle_pct = 26;
        rx_idle_pct = 87;
        random_phase(280, 1'b0);
        settle();
        write_sustain(16'd0);

        tx_idle_pct = 87;
        rx_idle_pct = 26;
        random_phase(230, 1'b1);
        settle();
        write_sustain(16'hFFFF);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(150, 1'b0);
        settle();
        write_sustain(16'($urandom));
        random_phase(150, 1'b0);
        send_item(tone_item(24'hABCDEF, 16'hFFFF, tqs_pkg::WAVE_SAW, 9'd256));
        settle();

        $display("Drove %0d items (%0d sample ticks) and checked %0d results,",
            items_sent, ticks_sent, checked);
        $display("with sustain at reset, zero, full scale and one random level.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/tqs_pkg.sv
sv/tqs_ram.sv
sv/tqs_datapath.sv
sv/tqs_ctrl.sv
sv/tone_queue_synth_voice.sv
sv/tqs_checker.sv
sim/tone_voice_checker.sv
sim/tone_queue_synth_voice_test.sv
